[src/slg_pkg.sv]
// slg_pkg: constants, types and elaboration-time tables for the srgb grayscale block
// depends on nothing; used by slg_quant and srgb_luminance_grayscale
`timescale 1ns / 1ps
package slg_pkg;

    localparam int LINEAR_FRAC_BITS = 16;
    localparam int PIX_W = 8;
    localparam int LIN_W = LINEAR_FRAC_BITS;
    localparam int WGT_W = 16;
    localparam int SUM_W = LINEAR_FRAC_BITS + WGT_W;
    localparam int NUM_LEVELS = 256;
    localparam int NUM_THR = NUM_LEVELS - 1;

    localparam logic [WGT_W-1:0] WEIGHT_R = 16'd13933;
    localparam logic [WGT_W-1:0] WEIGHT_G = 16'd46871;
    localparam logic [WGT_W-1:0] WEIGHT_B = 16'd4732;

    localparam longint unsigned Q31_ONE = 64'd1 << 31;
    localparam longint unsigned LIN_SCALE = (64'd1 << LINEAR_FRAC_BITS) - 64'd1;

    typedef logic [LIN_W-1:0] t_lin_tab [NUM_LEVELS];
    typedef logic [SUM_W-1:0] t_thr_tab [NUM_THR];
    typedef logic [NUM_THR-1:0] t_therm;

    function automatic longint unsigned f_mul_q31(longint unsigned a, longint unsigned b);
        return (a * b) >> 31;
    endfunction

    // restoring long division, only used while the tables are built
    function automatic longint unsigned f_div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // largest q1.31 value whose truncated fifth power stays at or below w
    function automatic longint unsigned f_root5_q31(longint unsigned w);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned m2;
        longint unsigned m4;
        longint unsigned m5;
        lo = 64'd0;
        hi = Q31_ONE;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            m2 = f_mul_q31(mid, mid);
            m4 = f_mul_q31(m2, m2);
            m5 = f_mul_q31(m4, mid);
            if (m5 <= w) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // linear value in q1.31 of srgb value n/d
    function automatic longint unsigned f_srgb_lin_q31(longint unsigned n, longint unsigned d);
        longint unsigned v;
        longint unsigned w;
        if (n * 64'd100000 < d * 64'd4045) begin
            return f_div_u64((n * 64'd100) << 31, d * 64'd1292);
        end
        v = f_div_u64((n * 64'd1000 + d * 64'd55) << 31, d * 64'd1055);
        if (v > Q31_ONE) begin
            v = Q31_ONE;
        end
        w = f_mul_q31(v, v);
        return f_mul_q31(w, f_root5_q31(w));
    endfunction

    function automatic t_lin_tab f_build_lin();
        t_lin_tab tab;
        longint unsigned lin;
        longint unsigned val;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lin = f_srgb_lin_q31(longint'(i), 64'd255);
            val = (lin * LIN_SCALE + (64'd1 << 30)) >> 31;
            tab[i] = val[LIN_W-1:0];
        end
        return tab;
    endfunction

    // midpoint thresholds, rounded up, in the scale of the luminance sum
    function automatic t_thr_tab f_build_thr();
        t_thr_tab tab;
        longint unsigned lin;
        longint unsigned val;
        for (int i = 0; i < NUM_THR; i++) begin
            lin = f_srgb_lin_q31(longint'(2 * i + 1), 64'd510);
            val = (lin * LIN_SCALE + ((64'd1 << 15) - 64'd1)) >> 15;
            tab[i] = val[SUM_W-1:0];
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = f_build_lin();
    localparam t_thr_tab THR_TAB = f_build_thr();

endpackage

[src/slg_quant.sv]
// slg_quant: turns the monotonic threshold thermometer into the gray code
// depends on slg_pkg
`timescale 1ns / 1ps
module slg_quant (
    input  slg_pkg::t_therm             i_therm,
    output logic [slg_pkg::PIX_W-1:0]   o_gray
);
    import slg_pkg::*;

    // binary search over the thermometer, one bit of the code per step
    always_comb begin
        logic [PIX_W-1:0] pos;
        logic [PIX_W:0]   probe;
        pos = '0;
        for (int b = PIX_W - 1; b >= 0; b--) begin
            probe = {1'b0, pos} + ((PIX_W + 1)'(1) << b) - (PIX_W + 1)'(1);
            if (i_therm[probe[PIX_W-1:0]]) begin
                pos = pos | (PIX_W'(1) << b);
            end
        end
        o_gray = pos;
    end

endmodule

[src/srgb_luminance_grayscale.sv]
// srgb_luminance_grayscale: srgb pixel to srgb gray level via rec.709 luminance
// depends on slg_pkg and slg_quant
//
// channel  | dir | tvalid/tready        | tdata
// ---------+-----+---------------------+--------------------------------
// slave    | in  | i_s_tvalid/o_s_tready | red[7:0] green[15:8] blue[23:16]
// master   | out | o_m_tvalid/i_m_tready | gray[7:0]
//
// five-stage pipeline: input register, table lookup and weight multiply,
// luminance sum, 255 parallel threshold compares, code search into the
// output register. one item per clock sustained while the output is not
// stalled; each accepted item passes through the stages in order.
// a stage loads when it is empty or the stage after it moves on, so bubbles
// collapse; once all five stages hold items a waiting result stalls the input.
// synchronous active-low reset clears only the stage valid bits.
`timescale 1ns / 1ps
module srgb_luminance_grayscale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // gray[7:0]
);
    import slg_pkg::*;

    localparam int NSTG = 5;
    localparam int PROD_W = LIN_W + WGT_W;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    // stage 1: input pixel
    logic [PIX_W-1:0]  r_red, r_green, r_blue;
    // stage 2: weighted linear channels
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    // stage 3: luminance sum
    logic [SUM_W-1:0]  r_sum;
    // stage 4: thermometer of thresholds reached
    t_therm            r_therm;
    t_therm            n_therm;
    // stage 5: output gray
    logic [PIX_W-1:0]  r_gray;
    logic [PIX_W-1:0]  n_gray;
    logic [PROD_W+1:0] sum_full;

    // stall chain from the output side
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // full-width sum cannot exceed the sum width: weights add to 2^16
    assign sum_full = {2'b00, r_prod_r} + {2'b00, r_prod_g} + {2'b00, r_prod_b};

    always_comb begin
        for (int k = 0; k < NUM_THR; k++) begin
            n_therm[k] = (r_sum >= THR_TAB[k]);
        end
    end

    slg_quant u_quant (
        .i_therm (r_therm),
        .o_gray  (n_gray)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_red   <= i_s_tdata[7:0];
            r_green <= i_s_tdata[15:8];
            r_blue  <= i_s_tdata[23:16];
        end
        if (adv[1]) begin
            r_prod_r <= PROD_W'(LIN_TAB[r_red])   * PROD_W'(WEIGHT_R);
            r_prod_g <= PROD_W'(LIN_TAB[r_green]) * PROD_W'(WEIGHT_G);
            r_prod_b <= PROD_W'(LIN_TAB[r_blue])  * PROD_W'(WEIGHT_B);
        end
        if (adv[2]) begin
            r_sum <= sum_full[SUM_W-1:0];
        end
        if (adv[3]) begin
            r_therm <= n_therm;
        end
        if (adv[4]) begin
            r_gray <= n_gray;
        end
    end

endmodule

[sim/slg_gray_checker.sv]
// slg_gray_checker: predicts the gray level of every accepted pixel and compares output items
// depends on nothing but the port widths of srgb_luminance_grayscale
`timescale 1ns / 1ps
module slg_gray_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // gray[7:0]
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint unsigned ONE_Q31 = 64'd1 << 31;
    localparam longint unsigned LIN_FULL = (64'd1 << 16) - 64'd1;
    localparam longint unsigned WR = 64'd13933;
    localparam longint unsigned WG = 64'd46871;
    localparam longint unsigned WB = 64'd4732;

    longint unsigned linear_of_code [256];
    longint unsigned midpoint_level [255];
    logic [7:0] gray_queue [$];

    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 31;
    endfunction

    // binary search for the largest root whose truncated fifth power fits
    function automatic longint unsigned fifth_root(longint unsigned x);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned probe;
        longint unsigned p4;
        lo = 0;
        hi = ONE_Q31;
        while (lo < hi) begin
            probe = lo + ((hi - lo + 1) >> 1);
            p4 = fx_mul(probe, probe);
            p4 = fx_mul(p4, p4);
            if (fx_mul(p4, probe) <= x) lo = probe;
            else hi = probe - 1;
        end
        return lo;
    endfunction

    // srgb value num/den to linear q1.31; power 2.4 as square times fifth root of square
    function automatic longint unsigned decode_srgb(longint unsigned num, longint unsigned den);
        longint unsigned v;
        longint unsigned sq;
        if (num * 100000 < den * 4045) return ((num * 100) << 31) / (den * 1292);
        v = ((num * 1000 + den * 55) << 31) / (den * 1055);
        if (v > ONE_Q31) v = ONE_Q31;
        sq = fx_mul(v, v);
        return fx_mul(sq, fifth_root(sq));
    endfunction

    function automatic logic [7:0] gray_of(logic [23:0] pix);
        longint unsigned lum;
        int unsigned level;
        level = 0;
        lum = WR * linear_of_code[pix[7:0]] + WG * linear_of_code[pix[15:8]]
            + WB * linear_of_code[pix[23:16]];
        for (int k = 0; k < 255; k++)
            if (lum >= midpoint_level[k]) level++;
        return level[7:0];
    endfunction

    initial begin
        // linear table rounds half up, thresholds round up in the sum scale
        for (int i = 0; i < 256; i++)
            linear_of_code[i] =
                (decode_srgb(longint'(i), 64'd255) * LIN_FULL + (64'd1 << 30)) >> 31;
        for (int i = 0; i < 255; i++)
            midpoint_level[i] = (decode_srgb(longint'(2 * i + 1), 64'd510) * LIN_FULL
                                 + ((64'd1 << 15) - 1)) >> 15;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) gray_queue.push_back(gray_of(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (gray_queue.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected gray item %0d with nothing pending", i_m_tdata);
                end else if (gray_queue[0] !== i_m_tdata) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("gray mismatch: expected %0d, got %0d",
                                 gray_queue[0], i_m_tdata);
                    void'(gray_queue.pop_front());
                end else begin
                    void'(gray_queue.pop_front());
                end
            end
        end
        o_pending <= gray_queue.size();
    end

endmodule

[sim/testbench.sv]
// testbench: pixel stimulus, idling and back-pressure for srgb_luminance_grayscale
// depends on srgb_luminance_grayscale and slg_gray_checker
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // gray[7:0]
    int          fail_count;
    int          pending;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    int          cycle_count;
    int          hold_left;
    logic        hold_req;
    logic        hold_taken;

    srgb_luminance_grayscale dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    slg_gray_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** srgb_luminance_grayscale: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // offer one pixel, idling first at the sender's rate; valid is low only while idling
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {blue, green, red};
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
    endtask

    // mostly uniform channels, sometimes extreme red and green, gray or dark red pixels
    task automatic send_random(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int n = 0; n < count; n++) begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            case ($urandom_range(9))
                0: begin
                    r = $urandom_range(1) ? 8'hff : 8'h00;
                    g = $urandom_range(1) ? 8'hff : 8'h00;
                end
                1: begin
                    g = r;
                    b = r;
                end
                2: r = 8'($urandom_range(15));
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 24'd0;
        hold_req = 1'b0;
        snd_idle_pct = 15;
        rcv_idle_pct = 64;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: black, white, primaries, secondaries, dark segment boundary near code 10/11, grays, mixes
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd10, 8'd11, 8'd12);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd254, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd85);
        send_pixel(8'd1, 8'd2, 8'd4);

        send_random(400);

        snd_idle_pct = 64;
        rcv_idle_pct = 15;
        send_random(400);

        // no idling; the long receiver hold-off fills the pipeline and stalls input
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req <= 1'b1;
        send_random(430);
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** srgb_luminance_grayscale: PASSED **");
        end else begin
            $display("** srgb_luminance_grayscale: FAILED **");
        end
        $finish;
    end

endmodule
